[sv/gdd_pkg.sv]
// Shared types and constants for the git delta instruction decoder.
// No dependencies; used by git_delta_instruction_decoder.
package gdd_pkg;

   // Default width of the decoded header sizes
   localparam int SIZE_BITS_DEFAULT = 32;

   // Decoder phase
   typedef enum logic [2:0] {
      PH_BASE_HDR,
      PH_RESULT_HDR,
      PH_CMD,
      PH_COPY_ARGS,
      PH_LITERAL
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_COPY    = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // End status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_FMT = 2'd1;
   localparam logic [1:0] STAT_NO_ROOM = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_LENGTH  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_CAPACITY = 8'd1;

   // Varint and command encodings
   localparam logic [6:0]  VARINT_MASK     = 7'h7f;
   localparam int          VARINT_STEP     = 7;
   localparam int          VARINT_MAX_SHIFT = 63;
   localparam logic [23:0] COPY_LEN_ZERO   = 24'h010000;

   // Result queue depth
   localparam int OQ_DEPTH = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  literal_byte;
      logic [31:0] copy_offset;
      logic [23:0] copy_length;
      logic [1:0]  status;
      logic        last;
   } result_type;

endpackage

[sv/git_delta_instruction_decoder.sv]
// Git pack delta decoder: one delta byte in per transaction, literal / copy / end results out.
// Uses gdd_pkg (phase enum, result struct, codes and constants).
// Results go to a four-entry result queue that sets req_ready and feeds rsp_ from its head.
// Throughput: one byte per cycle while req_ready is high; a byte that also ends the stream
// can yield two results, drained one per cycle while rsp_ready is high.
// Reset (synchronous, active high) clears stream state and the queue;
// base_length resets to 0 and out_capacity to all ones.
module git_delta_instruction_decoder #(
   parameter int SIZE_BITS = gdd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // delta byte input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_delta_byte,
   input  logic                              req_end_of_delta,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_literal_byte,
   output logic [31:0]                       rsp_copy_offset,
   output logic [23:0]                       rsp_copy_length,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gdd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                       csr_data
);

   localparam int CW      = (SIZE_BITS > 32) ? SIZE_BITS : 32;
   localparam int PTR_W   = $clog2(gdd_pkg::OQ_DEPTH);
   localparam int CNT_W   = $clog2(gdd_pkg::OQ_DEPTH + 1);

   // configuration
   logic [31:0] base_length_ff;
   logic [31:0] out_capacity_ff;

   // stream state
   gdd_pkg::phase_type phase_ff, phase_in;
   logic [SIZE_BITS-1:0] accum_ff, accum_in;
   logic [5:0]           shift_ff, shift_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;  // declared size minus bytes written
   logic [6:0]           flags_ff, flags_in;
   logic [31:0]          offset_ff, offset_in;
   logic [23:0]          length_ff, length_in;
   logic [6:0]           lit_left_ff, lit_left_in;
   logic                 error_ff, error_in;

   // result queue
   gdd_pkg::result_type  oq_mem [gdd_pkg::OQ_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 req_fire, rsp_fire;
   logic [7:0]           b;
   logic [6:0]           chunk;
   logic [3:0]           chunk_bits;
   logic [SIZE_BITS-1:0] accum_next;
   logic                 varint_bad;
   logic [6:0]           low_bit;
   logic [6:0]           flags_next;
   logic [31:0]          offset_next;
   logic [23:0]          length_next;
   logic                 do_copy;
   logic [31:0]          cp_off;
   logic [23:0]          cp_len;
   logic [23:0]          cp_size;
   logic                 copy_bad;
   logic [1:0]           st;
   logic                 fin_bad;
   logic                 r0_v, r1_v;
   gdd_pkg::result_type  r0, r1;
   logic                 slot0_v, slot1_v;
   gdd_pkg::result_type  slot0;
   logic [CNT_W-1:0]     push_n;

   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (count_ff <= CNT_W'(gdd_pkg::OQ_DEPTH - 2));
   assign b         = req_delta_byte;
   assign chunk     = b[6:0] & gdd_pkg::VARINT_MASK;

   // bit length of the varint chunk
   always_comb begin
      chunk_bits = 4'd0;
      for (int i = 0; i < 7; i++) begin
         if (chunk[i]) begin
            chunk_bits = 4'(i + 1);
         end
      end
   end

   assign accum_next = accum_ff | (SIZE_BITS'(chunk) << shift_ff);
   assign varint_bad =
      ((chunk != 7'd0) && ((7'(shift_ff) + 7'(chunk_bits)) > 7'(SIZE_BITS))) ||
      (b[7] && ((7'(shift_ff) + 7'(gdd_pkg::VARINT_STEP)) > 7'(gdd_pkg::VARINT_MAX_SHIFT)));

   // copy argument byte goes to the lowest pending flag position
   assign low_bit    = flags_ff & (~flags_ff + 7'd1);
   assign flags_next = flags_ff & ~low_bit;
   always_comb begin
      offset_next = offset_ff;
      length_next = length_ff;
      for (int i = 0; i < 4; i++) begin
         if (low_bit[i]) begin
            offset_next[8*i +: 8] = b;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (low_bit[4+i]) begin
            length_next[8*i +: 8] = b;
         end
      end
   end

   assign cp_size  = (cp_len == 24'd0) ? gdd_pkg::COPY_LEN_ZERO : cp_len;
   assign copy_bad = (cp_off > base_length_ff) ||
                     (32'(cp_size) > (base_length_ff - cp_off)) ||
                     (CW'(cp_size) > CW'(remaining_ff));

   always_comb begin
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      shift_in     = shift_ff;
      remaining_in = remaining_ff;
      flags_in     = flags_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      lit_left_in  = lit_left_ff;
      error_in     = error_ff;
      st           = gdd_pkg::STAT_OK;
      do_copy      = 1'b0;
      cp_off       = 32'd0;
      cp_len       = 24'd0;
      fin_bad      = 1'b0;
      r0_v         = 1'b0;
      r1_v         = 1'b0;
      r0           = '0;
      r1           = '0;

      if (req_fire) begin
         if (error_ff) begin
            // swallow bytes until the stream's last byte
            if (req_end_of_delta) begin
               error_in     = 1'b0;
               phase_in     = gdd_pkg::PH_BASE_HDR;
               accum_in     = '0;
               shift_in     = 6'd0;
               remaining_in = '0;
               flags_in     = 7'd0;
               offset_in    = 32'd0;
               length_in    = 24'd0;
               lit_left_in  = 7'd0;
            end
         end else begin
            case (phase_ff)
               gdd_pkg::PH_BASE_HDR, gdd_pkg::PH_RESULT_HDR: begin
                  if (varint_bad) begin
                     st = gdd_pkg::STAT_BAD_FMT;
                  end else if (!b[7]) begin
                     if (phase_ff == gdd_pkg::PH_BASE_HDR) begin
                        phase_in = gdd_pkg::PH_RESULT_HDR;
                     end else begin
                        remaining_in = accum_next;
                        phase_in     = gdd_pkg::PH_CMD;
                        if (CW'(accum_next) > CW'(out_capacity_ff)) begin
                           st = gdd_pkg::STAT_NO_ROOM;
                        end
                     end
                     accum_in = '0;
                     shift_in = 6'd0;
                  end else begin
                     accum_in = accum_next;
                     shift_in = shift_ff + 6'(gdd_pkg::VARINT_STEP);
                  end
               end
               gdd_pkg::PH_CMD: begin
                  if (b[7]) begin
                     flags_in  = b[6:0];
                     offset_in = 32'd0;
                     length_in = 24'd0;
                     if (b[6:0] == 7'd0) begin
                        do_copy = 1'b1;
                     end else begin
                        phase_in = gdd_pkg::PH_COPY_ARGS;
                     end
                  end else if (b != 8'd0) begin
                     if (CW'(b) > CW'(remaining_ff)) begin
                        st = gdd_pkg::STAT_BAD_FMT;
                     end else begin
                        lit_left_in = b[6:0];
                        phase_in    = gdd_pkg::PH_LITERAL;
                     end
                  end else begin
                     st = gdd_pkg::STAT_BAD_FMT;
                  end
               end
               gdd_pkg::PH_COPY_ARGS: begin
                  flags_in  = flags_next;
                  offset_in = offset_next;
                  length_in = length_next;
                  if (flags_next == 7'd0) begin
                     do_copy = 1'b1;
                     cp_off  = offset_next;
                     cp_len  = length_next;
                  end
               end
               gdd_pkg::PH_LITERAL: begin
                  r0_v              = 1'b1;
                  r0.kind           = gdd_pkg::KIND_LITERAL;
                  r0.literal_byte   = b;
                  remaining_in      = remaining_ff - SIZE_BITS'(1);
                  lit_left_in       = lit_left_ff - 7'd1;
                  if (lit_left_ff == 7'd1) begin
                     phase_in = gdd_pkg::PH_CMD;
                  end
               end
               default: begin
                  st = gdd_pkg::STAT_BAD_FMT;
               end
            endcase

            if (do_copy) begin
               phase_in = gdd_pkg::PH_CMD;
               if (copy_bad) begin
                  st = gdd_pkg::STAT_BAD_FMT;
               end else begin
                  r0_v           = 1'b1;
                  r0.kind        = gdd_pkg::KIND_COPY;
                  r0.copy_offset = cp_off;
                  r0.copy_length = cp_size;
                  remaining_in   = remaining_ff - SIZE_BITS'(cp_size);
               end
            end

            fin_bad = (phase_in != gdd_pkg::PH_CMD) || (remaining_in != '0);

            if (st != gdd_pkg::STAT_OK) begin
               r1_v      = 1'b1;
               r1.kind   = gdd_pkg::KIND_END;
               r1.status = st;
               r1.last   = 1'b1;
               if (!req_end_of_delta) begin
                  error_in = 1'b1;
               end
            end else if (req_end_of_delta) begin
               r1_v      = 1'b1;
               r1.kind   = gdd_pkg::KIND_END;
               r1.status = fin_bad ? gdd_pkg::STAT_BAD_FMT : gdd_pkg::STAT_OK;
               r1.last   = 1'b1;
            end

            if (req_end_of_delta) begin
               phase_in     = gdd_pkg::PH_BASE_HDR;
               accum_in     = '0;
               shift_in     = 6'd0;
               remaining_in = '0;
               flags_in     = 7'd0;
               offset_in    = 32'd0;
               length_in    = 24'd0;
               lit_left_in  = 7'd0;
               error_in     = 1'b0;
            end
         end
      end
   end

   // queue write: first result to wr_ptr, a second one right after it
   assign slot0_v = r0_v | r1_v;
   assign slot1_v = r0_v & r1_v;
   assign slot0   = r0_v ? r0 : r1;
   assign push_n  = CNT_W'(slot0_v) + CNT_W'(slot1_v);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_fire);
      count_in  = count_ff + push_n - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (slot0_v) begin
         oq_mem[wr_ptr_ff] <= slot0;
      end
      if (slot1_v) begin
         oq_mem[wr_ptr_ff + PTR_W'(1)] <= r1;
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_kind         = oq_mem[rd_ptr_ff].kind;
   assign rsp_literal_byte = oq_mem[rd_ptr_ff].literal_byte;
   assign rsp_copy_offset  = oq_mem[rd_ptr_ff].copy_offset;
   assign rsp_copy_length  = oq_mem[rd_ptr_ff].copy_length;
   assign rsp_status       = oq_mem[rd_ptr_ff].status;
   assign rsp_last         = oq_mem[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff  <= 32'd0;
         out_capacity_ff <= 32'hffff_ffff;
         phase_ff        <= gdd_pkg::PH_BASE_HDR;
         accum_ff        <= '0;
         shift_ff        <= 6'd0;
         remaining_ff    <= '0;
         flags_ff        <= 7'd0;
         offset_ff       <= 32'd0;
         length_ff       <= 24'd0;
         lit_left_ff     <= 7'd0;
         error_ff        <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == gdd_pkg::CSR_BASE_LENGTH) begin
               base_length_ff <= csr_data;
            end else if (csr_index == gdd_pkg::CSR_OUT_CAPACITY) begin
               out_capacity_ff <= csr_data;
            end
         end
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         shift_ff     <= shift_in;
         remaining_ff <= remaining_in;
         flags_ff     <= flags_in;
         offset_ff    <= offset_in;
         length_ff    <= length_in;
         lit_left_ff  <= lit_left_in;
         error_ff     <= error_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

endmodule
